/* design/elf_reloc_pkg.sv */
`default_nettype none
package elf_reloc_pkg;

  localparam logic [1:0] MachArm  = 2'd0;
  localparam logic [1:0] MachX64  = 2'd1;
  localparam logic [1:0] MachX86  = 2'd2;
  localparam logic [1:0] MachNone = 2'd3;

  localparam int unsigned WordW = 64;
  localparam int unsigned KindW = 8;
  localparam int unsigned MachW = 2;

  localparam logic [KindW-1:0] ArmNone     = 8'd0;
  localparam logic [KindW-1:0] ArmPc24     = 8'd1;
  localparam logic [KindW-1:0] ArmAbs32    = 8'd2;
  localparam logic [KindW-1:0] ArmRel32    = 8'd3;
  localparam logic [KindW-1:0] ArmAbs16    = 8'd5;
  localparam logic [KindW-1:0] ArmPlt32    = 8'd27;
  localparam logic [KindW-1:0] X64None     = 8'd0;
  localparam logic [KindW-1:0] X64Abs64    = 8'd1;
  localparam logic [KindW-1:0] X64Pc32     = 8'd2;
  localparam logic [KindW-1:0] X64Abs32    = 8'd10;
  localparam logic [KindW-1:0] X64Abs32s   = 8'd11;
  localparam logic [KindW-1:0] X64Abs16    = 8'd12;
  localparam logic [KindW-1:0] X86None     = 8'd0;
  localparam logic [KindW-1:0] X86Abs32    = 8'd1;
  localparam logic [KindW-1:0] X86Pc32     = 8'd2;
  localparam logic [KindW-1:0] X86Plt32    = 8'd4;
  localparam logic [KindW-1:0] X86Abs16    = 8'd20;
  localparam logic [KindW-1:0] KindUnknown = 8'hff;

  localparam logic [WordW-1:0] Mask16 = 64'h0000_0000_0000_ffff;
  localparam logic [WordW-1:0] Mask24 = 64'h0000_0000_00ff_ffff;
  localparam logic [WordW-1:0] Mask32 = 64'h0000_0000_ffff_ffff;

  typedef enum logic [2:0] {
    OpNone,
    OpAbs16,
    OpAbs32,
    OpAbs64,
    OpPc32,
    OpPc24,
    OpBad
  } op_e;

  function automatic op_e decode_op(input logic [MachW-1:0] mach,
                                    input logic [KindW-1:0] kind);
    op_e op;
    op = OpBad;
    unique case (mach)
      MachArm: begin
        unique case (kind)
          ArmNone:            op = OpNone;
          ArmAbs16:           op = OpAbs16;
          ArmAbs32:           op = OpAbs32;
          ArmRel32, ArmPlt32: op = OpPc32;
          ArmPc24:            op = OpPc24;
          default:            op = OpBad;
        endcase
      end
      MachX64: begin
        unique case (kind)
          X64None:             op = OpNone;
          X64Abs16:            op = OpAbs16;
          X64Abs32, X64Abs32s: op = OpAbs32;
          X64Abs64:            op = OpAbs64;
          X64Pc32:             op = OpPc32;
          default:             op = OpBad;
        endcase
      end
      MachX86: begin
        unique case (kind)
          X86None:           op = OpNone;
          X86Abs16:          op = OpAbs16;
          X86Abs32:          op = OpAbs32;
          X86Pc32, X86Plt32: op = OpPc32;
          default:           op = OpBad;
        endcase
      end
      default: op = OpBad;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

/* design/elf_relocation_patch.sv */
// Throughput: one request per cycle while the output is not stalled; the three register stages
// each take one 64-bit add or subtract, and a stage is held only while every later stage is full.
// Reset: rst_ni clears all stage valid bits and sets the target machine to ARM.
// The configuration write channel is always ready.
`default_nettype none
module elf_relocation_patch (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  wire logic [elf_reloc_pkg::MachW-1:0]          cfg_data_i,
  input  wire logic                                     in_valid_i,
  output logic                                          in_stall_o,
  input  wire logic [elf_reloc_pkg::KindW-1:0]          reloc_kind_i,
  input  wire logic [elf_reloc_pkg::WordW-1:0]          site_word_i,
  input  wire logic [elf_reloc_pkg::WordW-1:0]          symbol_value_i,
  input  wire logic signed [elf_reloc_pkg::WordW-1:0]   explicit_addend_i,
  input  wire logic [elf_reloc_pkg::WordW-1:0]          site_address_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic [elf_reloc_pkg::WordW-1:0]               patched_word_o,
  output logic                                          patch_status_o
);
  import elf_reloc_pkg::*;

  logic [MachW-1:0] mach_q;

  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [WordW-1:0] s1_word_q;
  logic [WordW-1:0] s1_val_q;
  logic [WordW-1:0] s1_place_q;

  logic             s2_valid_q;
  op_e              s2_op_q;
  logic [WordW-1:0] s2_word_q;
  logic [WordW-1:0] s2_delta_d;
  logic [WordW-1:0] s2_delta_q;

  logic             out_valid_q;
  logic [WordW-1:0] out_word_d;
  logic [WordW-1:0] out_word_q;
  logic             out_status_d;
  logic             out_status_q;

  logic             out_ready;
  logic             s2_ready;
  logic             s1_ready;
  logic [WordW-1:0] diff;
  logic [WordW-1:0] sum;

  assign cfg_ready_o = 1'b1;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mach_q <= MachArm;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mach_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_op_q    <= decode_op(mach_q, reloc_kind_i);
      s1_word_q  <= site_word_i;
      s1_val_q   <= symbol_value_i + $unsigned(explicit_addend_i);
      s1_place_q <= site_address_i;
    end
  end

  assign diff = s1_val_q - s1_place_q;

  always_comb begin
    unique case (s1_op_q)
      OpPc32:  s2_delta_d = diff;
      OpPc24:  s2_delta_d = diff >> 2;
      default: s2_delta_d = s1_val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_op_q    <= s1_op_q;
      s2_word_q  <= s1_word_q;
      s2_delta_q <= s2_delta_d;
    end
  end

  assign sum = s2_word_q + s2_delta_q;

  always_comb begin
    out_status_d = 1'b0;
    unique case (s2_op_q)
      OpAbs16:        out_word_d = (s2_word_q & ~Mask16) | (sum & Mask16);
      OpAbs32, OpPc32: out_word_d = (s2_word_q & ~Mask32) | (sum & Mask32);
      OpAbs64:        out_word_d = sum;
      OpPc24:         out_word_d = (s2_word_q & ~Mask24) | (sum & Mask24);
      OpBad: begin
        out_word_d   = s2_word_q;
        out_status_d = 1'b1;
      end
      default:        out_word_d = s2_word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_word_q   <= out_word_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign patched_word_o = out_word_q;
  assign patch_status_o = out_status_q;

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted request did not enter the first stage");

  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_q))
    else $error("input stalled while a pipeline stage was empty");

  a_s2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_ready) |=> (s2_valid_q && $stable(s2_delta_q)
                                    && $stable(s2_word_q)))
    else $error("second stage changed while held by a stall");

endmodule
`default_nettype wire

/* sim/elf_relocation_patch_tb.sv */
`timescale 1ns / 1ps

module elf_relocation_patch_tb;
  import elf_reloc_pkg::*;

  localparam int NumPhases = 7;
  localparam logic [MachW-1:0] PhaseMach [NumPhases] =
    '{MachArm, MachX64, MachX86, MachNone, MachX64, MachArm, MachX86};
  localparam int RandomPerPhase = 215;
  localparam int HoldOffAt = 500;
  localparam int HoldOffCycles = 300;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] site;
    logic [WordW-1:0] sym;
    logic [WordW-1:0] addend;
    logic [WordW-1:0] place;
  } reloc_req_t;

  typedef struct {
    logic [WordW-1:0] word;
    logic             status;
  } patch_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [MachW-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [KindW-1:0]     reloc_kind_i = '0;
  logic [WordW-1:0]     site_word_i = '0;
  logic [WordW-1:0]     symbol_value_i = '0;
  logic signed [WordW-1:0] explicit_addend_i = '0;
  logic [WordW-1:0]     site_address_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [WordW-1:0]     patched_word_o;
  logic                 patch_status_o;

  reloc_req_t pending_relocs[$];
  patch_res_t expected_patches[$];
  logic [MachW-1:0] model_mach = MachArm;
  int fail_count = 0;
  int accepted_count = 0;
  bit req_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  elf_relocation_patch DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .reloc_kind_i      (reloc_kind_i),
    .site_word_i       (site_word_i),
    .symbol_value_i    (symbol_value_i),
    .explicit_addend_i (explicit_addend_i),
    .site_address_i    (site_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .patched_word_o    (patched_word_o),
    .patch_status_o    (patch_status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic op_e classify_kind(input logic [MachW-1:0] mach,
                                        input logic [KindW-1:0] kind);
    op_e op;
    op = OpBad;
    if (mach == MachArm) begin
      case (kind)
        ArmNone:            op = OpNone;
        ArmAbs16:           op = OpAbs16;
        ArmAbs32:           op = OpAbs32;
        ArmRel32, ArmPlt32: op = OpPc32;
        ArmPc24:            op = OpPc24;
        default:            op = OpBad;
      endcase
    end else if (mach == MachX64) begin
      case (kind)
        X64None:              op = OpNone;
        X64Abs16:             op = OpAbs16;
        X64Abs32, X64Abs32s:  op = OpAbs32;
        X64Abs64:             op = OpAbs64;
        X64Pc32:              op = OpPc32;
        default:              op = OpBad;
      endcase
    end else if (mach == MachX86) begin
      case (kind)
        X86None:            op = OpNone;
        X86Abs16:           op = OpAbs16;
        X86Abs32:           op = OpAbs32;
        X86Pc32, X86Plt32:  op = OpPc32;
        default:            op = OpBad;
      endcase
    end
    return op;
  endfunction

  function automatic patch_res_t predict_patch(input logic [MachW-1:0] mach,
                                               input reloc_req_t r);
    patch_res_t res;
    logic [WordW-1:0] val;
    logic [WordW-1:0] rel;
    logic [WordW-1:0] shifted;
    val = r.sym + r.addend;
    rel = val - r.place;
    shifted = rel >> 2;
    res.word = r.site;
    res.status = 1'b0;
    case (classify_kind(mach, r.kind))
      OpNone:  res.word = r.site;
      OpAbs16: res.word = {r.site[63:16], r.site[15:0] + val[15:0]};
      OpAbs32: res.word = {r.site[63:32], r.site[31:0] + val[31:0]};
      OpAbs64: res.word = r.site + val;
      OpPc32:  res.word = {r.site[63:32], r.site[31:0] + rel[31:0]};
      OpPc24:  res.word = {r.site[63:24], r.site[23:0] + shifted[23:0]};
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return {32'h0, $urandom()};
      4:       return {$urandom(), 32'hffff_ffff};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_kind(input logic [MachW-1:0] mach);
    if ($urandom_range(0, 3) == 0 || mach == MachNone) begin
      return KindW'($urandom_range(0, 255));
    end
    if (mach == MachArm) begin
      case ($urandom_range(0, 5))
        0: return ArmNone;
        1: return ArmPc24;
        2: return ArmAbs32;
        3: return ArmRel32;
        4: return ArmAbs16;
        default: return ArmPlt32;
      endcase
    end else if (mach == MachX64) begin
      case ($urandom_range(0, 5))
        0: return X64None;
        1: return X64Abs64;
        2: return X64Pc32;
        3: return X64Abs32;
        4: return X64Abs32s;
        default: return X64Abs16;
      endcase
    end
    case ($urandom_range(0, 4))
      0: return X86None;
      1: return X86Abs32;
      2: return X86Pc32;
      3: return X86Plt32;
      default: return X86Abs16;
    endcase
  endfunction

  task automatic queue_directed(input logic [MachW-1:0] mach);
    logic [KindW-1:0] kinds[$];
    reloc_req_t r;
    case (mach)
      MachArm: kinds = {ArmNone, ArmAbs16, ArmAbs32, ArmRel32, ArmPlt32, ArmPc24};
      MachX64: kinds = {X64None, X64Abs16, X64Abs32, X64Abs32s, X64Abs64, X64Pc32};
      MachX86: kinds = {X86None, X86Abs16, X86Abs32, X86Pc32, X86Plt32};
      default: kinds = {X64None, X86Abs32};
    endcase
    kinds.push_back(KindUnknown);
    foreach (kinds[i]) begin
      r.kind = kinds[i];
      if (i % 2 == 0) begin
        r.site = '1;
        r.sym = '1;
        r.addend = 64'd1;
        r.place = '0;
      end else begin
        r.site = '0;
        r.sym = '0;
        r.addend = 64'h8000_0000_0000_0000;
        r.place = '1;
      end
      pending_relocs.push_back(r);
    end
  endtask

  task automatic queue_random(input logic [MachW-1:0] mach, input int count);
    reloc_req_t r;
    repeat (count) begin
      r.kind = pick_kind(mach);
      r.site = rand_word();
      r.sym = rand_word();
      r.addend = ($urandom_range(0, 3) == 0) ? '0 : rand_word();
      r.place = rand_word();
      pending_relocs.push_back(r);
    end
  endtask

  task automatic write_machine(input logic [MachW-1:0] mach);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = mach;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_relocs.size() != 0 || expected_patches.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin : req_driver
    reloc_req_t nxt;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_relocs.size() > 0) begin
        nxt = pending_relocs.pop_front();
        in_valid_i <= 1'b1;
        reloc_kind_i <= nxt.kind;
        site_word_i <= nxt.site;
        symbol_value_i <= nxt.sym;
        explicit_addend_i <= nxt.addend;
        site_address_i <= nxt.place;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk_i) begin : stall_gen
    bit stall_next;
    stall_next = 1'b0;
    if (!hold_done && accepted_count >= HoldOffAt) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 3) == 0);
        default: stall_next = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_stall_i <= stall_next;
  end

  always @(posedge clk_i) begin : monitor
    reloc_req_t seen;
    patch_res_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        model_mach = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        seen.kind = reloc_kind_i;
        seen.site = site_word_i;
        seen.sym = symbol_value_i;
        seen.addend = explicit_addend_i;
        seen.place = site_address_i;
        expected_patches.push_back(predict_patch(model_mach, seen));
        accepted_count++;
        req_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_patches.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: word %h status %b", patched_word_o, patch_status_o);
          end
          fail_count++;
        end else begin
          want = expected_patches.pop_front();
          if (patched_word_o !== want.word || patch_status_o !== want.status) begin
            if (fail_count < 10) begin
              $display("mismatch: expected word %h status %b, got word %h status %b",
                       want.word, want.status, patched_word_o, patch_status_o);
            end
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (8) @(posedge clk_i);
      write_machine(PhaseMach[p]);
      if (p < 4) begin
        queue_directed(PhaseMach[p]);
      end
      queue_random(PhaseMach[p], RandomPerPhase);
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_patches.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
